>>> rtl/ssb_pkg.sv
package ssb_pkg;

    // field widths fixed by the interface
    localparam int AXIS_W      = 16;
    localparam int SECTOR_W    = 4;
    localparam int SC_FIELD_W  = 5;
    localparam int THR_W       = 15;
    localparam int CFG_DATA_W  = 15;
    localparam int CFG_IDX_W   = 2;

    // angle and sector resolution
    localparam int ANGLE_BITS  = 16;
    localparam int MAX_SECTORS = 16;
    localparam int CNT_W       = $clog2(MAX_SECTORS + 1);
    localparam int PROD_W      = ANGLE_BITS + CNT_W;

    // cordic datapath
    localparam int CORDIC_STEPS = 24;
    localparam int ACC_W        = 32;
    localparam int PRESCALE     = 8;
    localparam int VEC_W        = 28;

    // length test
    localparam int SQ_W     = 2 * AXIS_W - 1;
    localparam int LEN_W    = SQ_W + 1;
    localparam int THR_SQ_W = 2 * THR_W;

    localparam logic [ACC_W-1:0] ACC_HALF_TURN    = 32'h8000_0000;
    localparam logic [ACC_W-1:0] ACC_QUARTER_TURN = 32'h4000_0000;

    localparam logic [CNT_W-1:0]    SECTOR_COUNT_RESET = CNT_W'(8);
    localparam logic [THR_SQ_W-1:0] THR_SQ_RESET       = THR_SQ_W'(24576 * 24576);

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [ACC_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SECTOR_COUNT    = 2'd0,
        REG_PRESS_THRESHOLD = 2'd1
    } cfg_reg_t;

    // vector in flight through the pipeline
    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic [ACC_W-1:0]        acc;
        logic                    press;
    } vec_t;

endpackage

>>> rtl/ssb_prep.sv
module ssb_prep (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [ssb_pkg::AXIS_W-1:0]   x_axis,
    input  logic signed [ssb_pkg::AXIS_W-1:0]   y_axis,
    input  logic [ssb_pkg::THR_SQ_W-1:0]        thr_sq,
    output logic                                out_valid,
    input  logic                                out_ready,
    output ssb_pkg::vec_t                       out_data
);

    localparam int EXT_W = ssb_pkg::VEC_W - ssb_pkg::AXIS_W - ssb_pkg::PRESCALE;

    logic                            sq_vld_reg;
    logic [ssb_pkg::SQ_W-1:0]        xsq_reg, xsq_next;
    logic [ssb_pkg::SQ_W-1:0]        ysq_reg, ysq_next;
    ssb_pkg::vec_t                   vec1_reg, vec1_next;
    logic                            len_vld_reg;
    ssb_pkg::vec_t                   vec2_reg, vec2_next;
    logic                            rdy1, rdy2;
    logic signed [2*ssb_pkg::AXIS_W-1:0] xprod, yprod;
    logic signed [ssb_pkg::VEC_W-1:0]    xs, ys;
    logic [ssb_pkg::LEN_W-1:0]           len_sq;

    // per-stage ready, bubbles collapse
    assign rdy2     = !len_vld_reg || out_ready;
    assign rdy1     = !sq_vld_reg || rdy2;
    assign in_ready = rdy1;

    // stage 1: squares, scale to q5.23 and fold the left half plane
    assign xprod = x_axis * x_axis;
    assign yprod = y_axis * y_axis;
    assign xs = {{EXT_W{x_axis[ssb_pkg::AXIS_W-1]}}, x_axis, {ssb_pkg::PRESCALE{1'b0}}};
    assign ys = {{EXT_W{y_axis[ssb_pkg::AXIS_W-1]}}, y_axis, {ssb_pkg::PRESCALE{1'b0}}};

    always_comb
    begin
        xsq_next = xprod[ssb_pkg::SQ_W-1:0];
        ysq_next = yprod[ssb_pkg::SQ_W-1:0];
        vec1_next.press = 1'b0;
        if (x_axis[ssb_pkg::AXIS_W-1])
        begin
            vec1_next.x   = -xs;
            vec1_next.y   = -ys;
            vec1_next.acc = ssb_pkg::ACC_HALF_TURN;
        end
        else
        begin
            vec1_next.x   = xs;
            vec1_next.y   = ys;
            vec1_next.acc = '0;
        end
    end

    // stage 2: squared length against squared threshold
    assign len_sq = {1'b0, xsq_reg} + {1'b0, ysq_reg};

    always_comb
    begin
        vec2_next       = vec1_reg;
        vec2_next.press = len_sq > ssb_pkg::LEN_W'(thr_sq);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_vld_reg  <= 1'b0;
            len_vld_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                sq_vld_reg <= in_valid;
            end
            if (rdy2)
            begin
                len_vld_reg <= sq_vld_reg;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            xsq_reg  <= xsq_next;
            ysq_reg  <= ysq_next;
            vec1_reg <= vec1_next;
        end
        if (rdy2)
        begin
            vec2_reg <= vec2_next;
        end
    end

    assign out_valid = len_vld_reg;
    assign out_data  = vec2_reg;

endmodule

>>> rtl/ssb_cordic.sv
module ssb_cordic (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  ssb_pkg::vec_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output ssb_pkg::vec_t out_data
);

    localparam int STEPS = ssb_pkg::CORDIC_STEPS;

    ssb_pkg::vec_t    stage_reg [STEPS];
    logic [STEPS-1:0] vld_reg;
    logic [STEPS:0]   rdy;

    assign rdy[STEPS] = out_ready;
    assign in_ready   = rdy[0];

    // one vectoring rotation per stage
    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        ssb_pkg::vec_t                    step_cur;
        ssb_pkg::vec_t                    step_next;
        logic                             cur_vld;
        logic signed [ssb_pkg::VEC_W-1:0] xs, ys;

        if (k == 0)
        begin : g_first
            assign step_cur = in_data;
            assign cur_vld  = in_valid;
        end
        else
        begin : g_rest
            assign step_cur = stage_reg[k-1];
            assign cur_vld  = vld_reg[k-1];
        end

        assign xs = $signed(step_cur.x) >>> k;
        assign ys = $signed(step_cur.y) >>> k;

        // rotate toward the x axis, both updates from the old values
        always_comb
        begin
            step_next = step_cur;
            if (!step_cur.y[ssb_pkg::VEC_W-1])
            begin
                step_next.x   = step_cur.x + ys;
                step_next.y   = step_cur.y - xs;
                step_next.acc = step_cur.acc + ssb_pkg::ATAN_TURNS[k];
            end
            else
            begin
                step_next.x   = step_cur.x - ys;
                step_next.y   = step_cur.y + xs;
                step_next.acc = step_cur.acc - ssb_pkg::ATAN_TURNS[k];
            end
        end

        assign rdy[k] = !vld_reg[k] || rdy[k+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (rdy[k])
            begin
                vld_reg[k] <= cur_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k])
            begin
                stage_reg[k] <= step_next;
            end
        end
    end

    assign out_valid = vld_reg[STEPS-1];
    assign out_data  = stage_reg[STEPS-1];

endmodule

>>> rtl/ssb_sector.sv
module ssb_sector (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  ssb_pkg::vec_t                    in_data,
    input  logic [ssb_pkg::CNT_W-1:0]        count,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             pressed,
    output logic [ssb_pkg::SECTOR_W-1:0]     sector_index
);

    logic                               vld_reg;
    logic                               pressed_reg, pressed_next;
    logic [ssb_pkg::SECTOR_W-1:0]       sector_reg, sector_next;
    logic [ssb_pkg::ACC_W-1:0]          ang;
    logic [ssb_pkg::ANGLE_BITS-1:0]     ang_bin;
    logic [ssb_pkg::PROD_W-1:0]         prod, rounded;
    logic [ssb_pkg::CNT_W-1:0]          sect_raw;

    assign in_ready = !vld_reg || out_ready;

    // quarter-turn offset, truncate to the binary angle
    assign ang     = in_data.acc + ssb_pkg::ACC_QUARTER_TURN;
    assign ang_bin = ang[ssb_pkg::ACC_W-1 -: ssb_pkg::ANGLE_BITS];

    // scale by sector count with half-sector rounding
    assign prod     = ssb_pkg::PROD_W'(ang_bin) * ssb_pkg::PROD_W'(count);
    assign rounded  = prod + (ssb_pkg::PROD_W'(1) << (ssb_pkg::ANGLE_BITS - 1));
    assign sect_raw = rounded[ssb_pkg::PROD_W-1:ssb_pkg::ANGLE_BITS];

    always_comb
    begin
        pressed_next = in_data.press;
        sector_next  = '0;
        if (in_data.press && (sect_raw < count))
        begin
            sector_next = sect_raw[ssb_pkg::SECTOR_W-1:0];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            pressed_reg <= pressed_next;
            sector_reg  <= sector_next;
        end
    end

    assign out_valid    = vld_reg;
    assign pressed      = pressed_reg;
    assign sector_index = sector_reg;

`ifndef SYNTHESIS
    // released sample always reports sector zero
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg && !pressed_reg |-> sector_reg == '0)
        else $error("sector nonzero while not pressed");

    // pressed sector lies inside the configured count
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg && pressed_reg |-> ssb_pkg::CNT_W'(sector_reg) < count)
        else $error("sector index beyond sector count");

    // stored sector count is always clamped
    assert property (@(posedge clk) disable iff (!rst_n)
        count != '0 && count <= ssb_pkg::CNT_W'(ssb_pkg::MAX_SECTORS))
        else $error("sector count out of range");
`endif

endmodule

>>> rtl/stick_sector_to_button_core.sv
// Stick sector quantizer: each (x_axis, y_axis) Q1.15 sample yields one result.
// pressed is 1 when x^2 + y^2 is strictly above press_threshold^2; sector_index
// is then the angle from a 24-step CORDIC, offset by a quarter turn and half a
// sector, cut into sector_count equal sectors (0 is read as 1, above 16 saturates
// to 16). A released sample reports sector 0. A new sample is taken every cycle
// unless stalled. Squares, length test, each rotation of the unrolled CORDIC and
// the sector scaling are registered in turn. Stalls hold stages in place and
// bubbles collapse. Configuration writes take effect at the next clock; the user
// must make them while no sample is in flight; the block does not enforce this.
module stick_sector_to_button_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [ssb_pkg::AXIS_W-1:0]   x_axis,
    input  logic signed [ssb_pkg::AXIS_W-1:0]   y_axis,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                pressed,
    output logic [ssb_pkg::SECTOR_W-1:0]        sector_index,
    input  logic                                cfg_write,
    input  logic [ssb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ssb_pkg::CFG_DATA_W-1:0]      cfg_data
);

    logic [ssb_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [ssb_pkg::THR_SQ_W-1:0]   thr_sq_reg, thr_sq_next;
    logic [ssb_pkg::SC_FIELD_W-1:0] count_field;
    logic [ssb_pkg::THR_W-1:0]      thr_field;

    logic          prep_valid, prep_ready;
    ssb_pkg::vec_t prep_data;
    logic          cord_valid, cord_ready;
    ssb_pkg::vec_t cord_data;

    // register writes, count clamped and threshold squared on the way in
    assign count_field = cfg_data[ssb_pkg::SC_FIELD_W-1:0];
    assign thr_field   = cfg_data[ssb_pkg::THR_W-1:0];

    always_comb
    begin
        count_next  = count_reg;
        thr_sq_next = thr_sq_reg;
        if (cfg_write)
        begin
            unique case (ssb_pkg::cfg_reg_t'(cfg_index))
                ssb_pkg::REG_SECTOR_COUNT:
                begin
                    if (count_field == '0)
                    begin
                        count_next = ssb_pkg::CNT_W'(1);
                    end
                    else if (count_field > ssb_pkg::SC_FIELD_W'(ssb_pkg::MAX_SECTORS))
                    begin
                        count_next = ssb_pkg::CNT_W'(ssb_pkg::MAX_SECTORS);
                    end
                    else
                    begin
                        count_next = ssb_pkg::CNT_W'(count_field);
                    end
                end
                ssb_pkg::REG_PRESS_THRESHOLD:
                begin
                    thr_sq_next = ssb_pkg::THR_SQ_W'(thr_field)
                                * ssb_pkg::THR_SQ_W'(thr_field);
                end
                default:
                begin
                    count_next  = count_reg;
                    thr_sq_next = thr_sq_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= ssb_pkg::SECTOR_COUNT_RESET;
            thr_sq_reg <= ssb_pkg::THR_SQ_RESET;
        end
        else
        begin
            count_reg  <= count_next;
            thr_sq_reg <= thr_sq_next;
        end
    end

    // squares, length test and half-plane fold
    ssb_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .x_axis    (x_axis),
        .y_axis    (y_axis),
        .thr_sq    (thr_sq_reg),
        .out_valid (prep_valid),
        .out_ready (prep_ready),
        .out_data  (prep_data)
    );

    // angle pipeline
    ssb_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prep_valid),
        .in_ready  (prep_ready),
        .in_data   (prep_data),
        .out_valid (cord_valid),
        .out_ready (cord_ready),
        .out_data  (cord_data)
    );

    // sector scaling and output register
    ssb_sector u_sector (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (cord_valid),
        .in_ready     (cord_ready),
        .in_data      (cord_data),
        .count        (count_reg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pressed      (pressed),
        .sector_index (sector_index)
    );

endmodule
